[design/lcwc_pkg.sv]
package lcwc_pkg;

    // Calibration table, Q16 kg, raw point to actual point
    localparam int CAL_POINTS = 5;
    localparam int SEG_CNT    = CAL_POINTS - 1;
    localparam int SEG_W      = $clog2(SEG_CNT);
    localparam int DY_W       = 20;

    localparam logic signed [31:0] CAL_IN [CAL_POINTS] =
        '{32'sd0, 32'sd327680, 32'sd655360, 32'sd1310720, 32'sd1966080};
    localparam logic signed [31:0] CAL_OUT [CAL_POINTS] =
        '{32'sd0, 32'sd327680, 32'sd656671, 32'sd1307443, 32'sd1966080};

    // per segment: rise, and run as five times a power of two
    localparam logic [DY_W-1:0] CAL_DY [SEG_CNT] =
        '{20'd327680, 20'd328991, 20'd650772, 20'd658637};
    localparam logic [4:0] CAL_SHIFT [SEG_CNT] = '{5'd16, 5'd16, 5'd17, 5'd17};

    // divide by five as (x * RECIP_5) >> RECIP_SHIFT, exact for x below 2^34;
    // x is multiplied one half at a time
    localparam int HALF_W      = 17;
    localparam int DVD_W       = 2 * HALF_W;
    localparam int RECIP_W     = 34;
    localparam logic [RECIP_W-1:0] RECIP_5 = 34'h333333334;
    localparam int RECIP_SHIFT = 36;

    // item kinds
    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_TIMEOUT = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;
    localparam logic [1:0] KIND_CLEAR   = 2'd3;

    localparam logic [23:0] RAW_INVALID = 24'h800000;
    localparam logic [15:0] TICKS_MAX   = 16'hFFFF;

    // register indexes
    localparam logic [2:0] REG_ZERO_OFFSET    = 3'd0;
    localparam logic [2:0] REG_COUNT_SCALE    = 3'd1;
    localparam logic [2:0] REG_SPIKE_LIMIT    = 3'd2;
    localparam logic [2:0] REG_AVERAGE_SHIFT  = 3'd3;
    localparam logic [2:0] REG_DEADBAND_WIDTH = 3'd4;
    localparam logic [2:0] REG_STALE_TICKS    = 3'd5;

    localparam logic [3:0] SHIFT_MAX = 4'd8;

    typedef struct packed {
        logic signed [23:0] zero_offset;
        logic signed [31:0] count_scale;
        logic [23:0]        spike_limit;
        logic [3:0]         average_shift;
        logic [15:0]        deadband_width;
        logic [15:0]        stale_ticks;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scale;
        logic seg;
        logic mul;
        logic dload;
        logic rlo;
        logic rhi;
        logic quo;
        logic sum;
        logic filt;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       skip;
        logic       pass;
        logic       out_free;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh000000007FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sh0000000080000000) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

[design/load_cell_weight_conditioner_core.sv]
// A calibrated sample runs through the scale, segment, multiply, divide and sum steps;
// one that falls at or below zero kg goes from the segment step straight to the
// filter, and every other word straight to the output. One word is in work at a time
// and a held-off output holds off the next; the calibration multiply and the divide by
// five, as two half-width reciprocal products and a final add, make the longest path.
// Reset (synchronous, active low) clears the filter state, the online flag, the tick
// count and the output valid, and loads the register defaults.
module load_cell_weight_conditioner_core import lcwc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] raw_sample
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] weight
    output logic [0:0]  m_axis_tuser,   // [0] online
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    lcwc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lcwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    lcwc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_kind      (s_axis_tuser),
        .i_raw       (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_weight    (m_axis_tdata),
        .o_online    (m_axis_tuser[0]),
        .o_out_valid (m_axis_tvalid)
    );

endmodule

[design/lcwc_regs.sv]
module lcwc_regs import lcwc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_offset    <= 24'sd0;
            r_cfg.count_scale    <= 32'sd4294;
            r_cfg.spike_limit    <= 24'd983040;
            r_cfg.average_shift  <= 4'd2;
            r_cfg.deadband_width <= 16'd3277;
            r_cfg.stale_ticks    <= 16'd500;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ZERO_OFFSET:    r_cfg.zero_offset    <= pwdata[23:0];
                REG_COUNT_SCALE:    r_cfg.count_scale    <= pwdata;
                REG_SPIKE_LIMIT:    r_cfg.spike_limit    <= pwdata[23:0];
                REG_AVERAGE_SHIFT:  r_cfg.average_shift  <= pwdata[3:0];
                REG_DEADBAND_WIDTH: r_cfg.deadband_width <= pwdata[15:0];
                REG_STALE_TICKS:    r_cfg.stale_ticks    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ZERO_OFFSET:    prdata = {8'd0, r_cfg.zero_offset};
            REG_COUNT_SCALE:    prdata = r_cfg.count_scale;
            REG_SPIKE_LIMIT:    prdata = {8'd0, r_cfg.spike_limit};
            REG_AVERAGE_SHIFT:  prdata = {28'd0, r_cfg.average_shift};
            REG_DEADBAND_WIDTH: prdata = {16'd0, r_cfg.deadband_width};
            REG_STALE_TICKS:    prdata = {16'd0, r_cfg.stale_ticks};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

[design/lcwc_dp.sv]
module lcwc_dp import lcwc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_kind,
    input  logic [23:0] i_raw,
    input  logic        i_out_ready,
    output t_stat       o_stat,
    output logic [31:0] o_weight,
    output logic        o_online,
    output logic        o_out_valid
);

    // captured word
    logic [1:0]         r_kind;
    logic signed [23:0] r_raw;

    // pipeline of the sample path
    logic signed [56:0]          r_prod1;
    logic signed [31:0]          r_kg;
    logic [SEG_W-1:0]            r_seg;
    logic [31:0]                 r_d;
    logic [51:0]                 r_prod2;
    logic [DVD_W-1:0]            r_dvd;
    logic [HALF_W+RECIP_W-1:0]   r_rlo;
    logic [HALF_W+RECIP_W-1:0]   r_rhi;
    logic [31:0]                 r_quo;
    logic signed [31:0]          r_cur;

    // filter state
    logic signed [31:0] r_filt;
    logic signed [31:0] r_prev;
    logic [15:0]        r_ticks;
    logic               r_online;

    // output register
    logic [31:0]        r_weight;
    logic               r_out_online;
    logic               r_out_valid;

    logic signed [24:0]          raw_diff;
    logic signed [56:0]          prod1_n;
    logic signed [31:0]          kg_n;
    logic [SEG_W-1:0]            seg_n;
    logic                        pass;
    logic [31:0]                 d_n;
    logic [51:0]                 prod2_n;
    logic [DVD_W-1:0]            dvd_ld;
    logic [HALF_W-1:0]           recip_op;
    logic [HALF_W+RECIP_W-1:0]   recip_prod;
    logic [DVD_W+RECIP_W-1:0]    recip_sum;
    logic signed [31:0]          cur_n;
    logic signed [32:0]          jump;
    logic [32:0]                 jump_abs;
    logic [3:0]                  shift_amt;
    logic signed [32:0]          ema_diff;
    logic signed [32:0]          ema_step;
    logic signed [31:0]          filt_n;
    logic                        stale;
    logic [31:0]                 filt_abs;
    logic                        in_band;

    assign raw_diff = 25'(i_cfg.zero_offset) - 25'(r_raw);
    assign prod1_n  = raw_diff * i_cfg.count_scale;
    assign kg_n     = sat32(64'(r_prod1 >>> 16));

    // first segment whose upper point is not below the value; last one extrapolates
    always_comb begin
        seg_n = SEG_W'(SEG_CNT - 1);
        for (int i = SEG_CNT - 2; i >= 0; i--) begin
            if (r_kg <= CAL_IN[i+1]) begin
                seg_n = SEG_W'(i);
            end
        end
    end

    assign pass    = r_kg <= CAL_IN[0];
    assign d_n     = 32'(r_kg - CAL_IN[seg_n]);
    assign prod2_n = r_d * CAL_DY[r_seg];
    assign dvd_ld  = DVD_W'(r_prod2 >> CAL_SHIFT[r_seg]);

    // divide by five: one reciprocal product per half, low half first
    assign recip_op   = i_cmd.rhi ? r_dvd[DVD_W-1:HALF_W] : r_dvd[HALF_W-1:0];
    assign recip_prod = recip_op * RECIP_5;
    assign recip_sum  = {r_rhi, {HALF_W{1'b0}}} + (DVD_W+RECIP_W)'(r_rlo);

    assign cur_n = sat32(64'(CAL_OUT[r_seg]) + 64'(r_quo));

    assign jump      = 33'(r_cur) - 33'(r_prev);
    assign jump_abs  = jump[32] ? 33'(-jump) : 33'(jump);
    assign shift_amt = (i_cfg.average_shift > SHIFT_MAX) ? SHIFT_MAX : i_cfg.average_shift;
    assign ema_diff  = 33'(r_cur) - 33'(r_filt);
    assign ema_step  = ema_diff >>> shift_amt;
    assign filt_n    = sat32(64'(r_filt) + 64'(ema_step));

    assign stale    = r_ticks > i_cfg.stale_ticks;
    assign filt_abs = r_filt[31] ? 32'(-r_filt) : 32'(r_filt);
    assign in_band  = filt_abs < 32'(i_cfg.deadband_width);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_raw  <= i_raw;
        end
        if (i_cmd.exec) begin
            r_prod1 <= prod1_n;
        end
        if (i_cmd.scale) begin
            r_kg <= kg_n;
        end
        if (i_cmd.seg) begin
            r_seg <= seg_n;
            r_d   <= d_n;
            r_cur <= r_kg;
        end
        if (i_cmd.mul) begin
            r_prod2 <= prod2_n;
        end
        if (i_cmd.dload) begin
            r_dvd <= dvd_ld;
        end
        if (i_cmd.rlo) begin
            r_rlo <= recip_prod;
        end
        if (i_cmd.rhi) begin
            r_rhi <= recip_prod;
        end
        if (i_cmd.quo) begin
            r_quo <= recip_sum[DVD_W+RECIP_W-1:RECIP_SHIFT];
        end
        if (i_cmd.sum) begin
            r_cur <= cur_n;
        end
        if (i_cmd.finish) begin
            r_weight     <= (stale || in_band) ? 32'd0 : r_filt;
            r_out_online <= r_online && !stale;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt      <= '0;
            r_prev      <= '0;
            r_ticks     <= '0;
            r_online    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                unique case (r_kind)
                    KIND_SAMPLE: begin
                        r_online <= 1'b1;
                        r_ticks  <= '0;
                    end
                    KIND_TIMEOUT: r_online <= 1'b0;
                    KIND_TICK: begin
                        if (r_ticks != TICKS_MAX) begin
                            r_ticks <= r_ticks + 16'd1;
                        end
                    end
                    KIND_CLEAR: r_filt <= '0;
                    default: ;
                endcase
            end
            if (i_cmd.filt) begin
                if (jump_abs < 33'(i_cfg.spike_limit)) begin
                    r_filt <= filt_n;
                end
                r_prev <= r_cur;
            end
            if (i_cmd.finish && stale) begin
                r_online <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.kind     = r_kind;
    assign o_stat.skip     = (r_raw == 24'sd0) || (r_raw == RAW_INVALID);
    assign o_stat.pass     = pass;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_weight    = r_weight;
    assign o_online    = r_out_online;
    assign o_out_valid = r_out_valid;

endmodule

[design/lcwc_ctrl.sv]
module lcwc_ctrl import lcwc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_SCALE = 4'd2;
    localparam logic [3:0] S_SEG   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DLOAD = 4'd5;
    localparam logic [3:0] S_RLO   = 4'd6;
    localparam logic [3:0] S_RHI   = 4'd7;
    localparam logic [3:0] S_QUO   = 4'd8;
    localparam logic [3:0] S_SUM   = 4'd9;
    localparam logic [3:0] S_FILT  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.kind == KIND_SAMPLE && !i_stat.skip) begin
                    n_state = S_SCALE;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_SEG;
            end
            S_SEG: begin
                // at or below the first point the value bypasses calibration
                o_cmd.seg = 1'b1;
                n_state   = i_stat.pass ? S_FILT : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DLOAD;
            end
            S_DLOAD: begin
                o_cmd.dload = 1'b1;
                n_state     = S_RLO;
            end
            S_RLO: begin
                o_cmd.rlo = 1'b1;
                n_state   = S_RHI;
            end
            S_RHI: begin
                o_cmd.rhi = 1'b1;
                n_state   = S_QUO;
            end
            S_QUO: begin
                o_cmd.quo = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_FILT;
            end
            S_FILT: begin
                o_cmd.filt = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/lcwc_checker.sv]
module lcwc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        pready
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // one word in flight: input closes right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted again while busy");

    // no result can appear in the cycle after an accept
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    // a new result only comes out of a busy block
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result without work in progress");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind load_cell_weight_conditioner_core lcwc_checker u_lcwc_checker (.*);
